FILE: rtl/kaplan_meier_survival_assert.svh
// Assertion macros for the RTL
`ifndef KAPLAN_MEIER_SURVIVAL_ASSERT_SVH
`define KAPLAN_MEIER_SURVIVAL_ASSERT_SVH

// assert that a condition implies a consequence on the same edge
`define KMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// assert that a condition implies a consequence on the next edge
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/kms_pkg.sv
`default_nettype none
package kms_pkg;
    localparam int MaxObs    = 64;
    localparam int TimeBits  = 32;
    localparam int IdxBits   = $clog2(MaxObs);
    localparam int CntBits   = $clog2(MaxObs + 1);
    localparam int SurvBits  = 17;
    localparam logic [SurvBits-1:0] OneQ16 = 17'd65536;

    typedef struct packed {
        logic [31:0] obs_time;
        logic        is_event;
        logic        is_missing;
        logic        last_obs;
    } t_in;

    typedef struct packed {
        logic [31:0]         event_time;
        logic [SurvBits-1:0] incidence;
        logic                empty_result;
        logic                overflowed;
        logic                last_result;
    } t_out;
endpackage
`default_nettype wire

FILE: rtl/kms_div.sv
`default_nettype none
// Restoring divider: quotient = floor(num / den), one quotient bit per cycle.
module kms_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [kms_pkg::SurvBits+kms_pkg::CntBits-1:0] i_num,
    input  wire logic [kms_pkg::CntBits-1:0]  i_den,
    output logic                              o_done,
    output logic [kms_pkg::SurvBits-1:0]      o_quot
);
    import kms_pkg::*;
    localparam int NumBits = SurvBits + CntBits;
    localparam int StepBits = $clog2(NumBits + 1);

    logic [NumBits-1:0]  r_num;
    logic [CntBits-1:0]  r_rem;
    logic [CntBits-1:0]  r_den;
    logic [StepBits-1:0] r_step;
    logic                r_busy;
    logic [CntBits:0]    n_rem_sh;

    assign n_rem_sh = {r_rem, r_num[NumBits-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_step <= StepBits'(NumBits);
            end else if (r_busy) begin
                // shift in one numerator bit, subtract where it fits
                if (n_rem_sh >= {1'b0, r_den}) begin
                    r_rem <= CntBits'(n_rem_sh - {1'b0, r_den});
                    r_num <= {r_num[NumBits-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh[CntBits-1:0];
                    r_num <= {r_num[NumBits-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == StepBits'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits collect in the numerator register
    assign o_quot = r_num[SurvBits-1:0];
endmodule
`default_nettype wire

FILE: rtl/kaplan_meier_survival.sv
`default_nettype none
// Channel  Direction  Payload  Handshake
// in       input      t_in     i_in_valid / o_in_stall
// out      output     t_out    o_out_valid / i_out_stall
//
// Loading stores each accepted observation that is not missing, up to MaxObs.
// On last_obs: insertion sort over the store, each compare-and-shift through the
// states S_SRD and S_SCMP and a single memory read port; then a walk over the
// entries, with a division for each event time.
// One result is held back until the next is known, so the final one carries last_result.
// The input is stalled during sort, walk and output; a stalled output holds the sequencer.
// Reset is synchronous and returns the run to empty with survival one.
module kaplan_meier_survival (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire kms_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output kms_pkg::t_out      o_out
);
    import kms_pkg::*;
`include "kaplan_meier_survival_assert.svh"

    typedef enum logic [3:0] {
        S_LOAD, S_SI, S_SRD, S_SCMP, S_SPUT,
        S_WRD, S_WACC, S_DIV, S_DWAIT, S_EMIT, S_FIN
    } t_state;

    t_state r_state;
    logic [TimeBits-1:0] r_tmem [MaxObs];
    logic                r_emem [MaxObs];
    logic [CntBits-1:0]  r_cnt;
    logic                r_ovf;
    logic [SurvBits-1:0] r_surv;
    logic [CntBits-1:0]  r_i, r_j;
    logic [TimeBits-1:0] r_key, r_rd_t, r_grp_t;
    logic                r_key_e, r_rd_e;
    logic [CntBits-1:0]  r_d, r_r;
    logic                r_open, r_have_out;
    t_out                r_pend;
    logic                r_div_start;
    logic                div_done;
    logic [SurvBits-1:0] div_quot;
    logic [SurvBits+CntBits-1:0] prod;
    logic                accept_in, accept_out, out_free;

    assign accept_in  = i_in_valid && !o_in_stall;
    assign accept_out = o_out_valid && !i_out_stall;
    assign out_free   = !o_out_valid || accept_out;
    assign o_in_stall = (r_state != S_LOAD);

    // S * (r - d), at most 17x7 bits
    assign prod = (SurvBits+CntBits)'(r_surv) * (SurvBits+CntBits)'(r_r - r_d);

    kms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (prod),
        .i_den   (r_r),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_surv      <= OneQ16;
            o_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_open      <= 1'b0;
            r_have_out  <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept_in) begin
                        if (!i_in.is_missing) begin
                            if (r_cnt < CntBits'(MaxObs)) begin
                                r_tmem[r_cnt[IdxBits-1:0]] <= i_in.obs_time[TimeBits-1:0];
                                r_emem[r_cnt[IdxBits-1:0]] <= i_in.is_event;
                                r_cnt <= r_cnt + 1'b1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        if (i_in.last_obs) begin
                            r_i     <= CntBits'(1);
                            r_state <= S_SI;
                        end
                    end
                end
                S_SI: begin
                    // pick up the next key to insert
                    if (r_i >= r_cnt) begin
                        r_i     <= '0;
                        r_open  <= 1'b0;
                        r_state <= S_WRD;
                    end else begin
                        r_key   <= r_tmem[r_i[IdxBits-1:0]];
                        r_key_e <= r_emem[r_i[IdxBits-1:0]];
                        r_j     <= r_i;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_j == '0) begin
                        r_state <= S_SPUT;
                    end else begin
                        r_rd_t  <= r_tmem[IdxBits'(r_j - 1'b1)];
                        r_rd_e  <= r_emem[IdxBits'(r_j - 1'b1)];
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (r_rd_t > r_key) begin
                        // shift the larger entry up one place
                        r_tmem[r_j[IdxBits-1:0]] <= r_rd_t;
                        r_emem[r_j[IdxBits-1:0]] <= r_rd_e;
                        r_j     <= r_j - 1'b1;
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_SPUT;
                    end
                end
                S_SPUT: begin
                    r_tmem[r_j[IdxBits-1:0]] <= r_key;
                    r_emem[r_j[IdxBits-1:0]] <= r_key_e;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SI;
                end
                S_WRD: begin
                    // fetch entry i of the sorted store
                    if (r_i < r_cnt) begin
                        r_rd_t <= r_tmem[r_i[IdxBits-1:0]];
                        r_rd_e <= r_emem[r_i[IdxBits-1:0]];
                    end
                    r_state <= S_WACC;
                end
                S_WACC: begin
                    if (r_i < r_cnt && !r_open) begin
                        // open a group at entry i
                        r_grp_t <= r_rd_t;
                        r_r     <= r_cnt - r_i;
                        r_d     <= CntBits'(r_rd_e);
                        r_open  <= 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_WRD;
                    end else if (r_i < r_cnt && r_rd_t == r_grp_t) begin
                        r_d     <= r_d + CntBits'(r_rd_e);
                        r_i     <= r_i + 1'b1;
                        r_state <= S_WRD;
                    end else if (r_open) begin
                        // close the group; update survival only where it had an event
                        r_open <= 1'b0;
                        if (r_d != '0) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else begin
                            r_state <= S_WRD;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_div_start <= 1'b0;
                    r_state     <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_surv  <= div_quot;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold a finished result until the previous one is taken
                    if (!r_have_out || out_free) begin
                        if (r_have_out) o_out <= r_pend;
                        r_pend <= '{event_time: r_grp_t, incidence: OneQ16 - r_surv,
                                    empty_result: 1'b0, overflowed: r_ovf,
                                    last_result: 1'b0};
                        r_have_out <= 1'b1;
                        r_state    <= S_WRD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        if (r_have_out) begin
                            o_out <= '{event_time: r_pend.event_time,
                                       incidence: r_pend.incidence,
                                       empty_result: 1'b0,
                                       overflowed: r_pend.overflowed,
                                       last_result: 1'b1};
                        end else begin
                            o_out <= '{event_time: '0, incidence: '0, empty_result: 1'b1,
                                       overflowed: r_ovf, last_result: 1'b1};
                        end
                        r_have_out <= 1'b0;
                        r_cnt      <= '0;
                        r_ovf      <= 1'b0;
                        r_surv     <= OneQ16;
                        r_state    <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            // present a new transfer, or drop valid once the current one is taken
            if ((r_state == S_EMIT && r_have_out && out_free) || (r_state == S_FIN && out_free))
                o_out_valid <= 1'b1;
            else if (accept_out)
                o_out_valid <= 1'b0;
        end
    end

    `KMS_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_LOAD, o_in_stall)
    `KMS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CntBits'(MaxObs))
    `KMS_ASSERT_NEXT(a_fin_last, i_clk, i_rst_n,
        r_state == S_FIN && out_free, o_out_valid && o_out.last_result)
    `KMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
endmodule
`default_nettype wire

FILE: tb/kaplan_meier_survival_tb.sv
`default_nettype none
module kaplan_meier_survival_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kms_pkg::*;

    localparam int CycleLimit = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    always #2 i_clk = ~i_clk;

    kaplan_meier_survival dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    // predictor state: the observations of the current run
    logic [31:0] run_times[$];
    logic        run_events[$];
    logic        run_overflow = 1'b0;
    t_out        pending_results[$];

    int errors = 0;
    int n_results = 0;
    int n_runs = 0;
    int n_overflow_runs = 0;
    int n_empty_runs = 0;
    longint cycles = 0;
    logic hold_off = 1'b0;

    // load one observation and, on the run's last item, compute the curve
    task automatic predict_survival(input t_in item);
        logic [31:0] st[$];
        logic        se[$];
        logic [31:0] t, tmp;
        logic        e;
        logic [16:0] surv;
        t_out        res;
        int n, i, r, d, found;
        if (!item.is_missing) begin
            if (run_times.size() < MaxObs) begin
                run_times.insert(run_times.size(), item.obs_time);
                run_events.insert(run_events.size(), item.is_event);
            end else begin
                run_overflow = 1'b1;
            end
        end
        if (!item.last_obs) return;
        st = run_times;
        se = run_events;
        n = st.size();
        for (int a = 1; a < n; a++) begin
            for (int b = a; b > 0 && st[b-1] > st[b]; b--) begin
                tmp = st[b]; st[b] = st[b-1]; st[b-1] = tmp;
                e = se[b]; se[b] = se[b-1]; se[b-1] = e;
            end
        end
        surv = OneQ16;
        found = 0;
        i = 0;
        while (i < n) begin
            t = st[i];
            r = n - i;
            d = 0;
            while (i < n && st[i] == t) begin
                d += se[i];
                i++;
            end
            if (d > 0) begin
                surv = 17'((64'(surv) * 64'(r - d)) / 64'(r));
                res = '{event_time: t, incidence: OneQ16 - surv, empty_result: 1'b0,
                        overflowed: run_overflow, last_result: 1'b0};
                pending_results.insert(pending_results.size(), res);
                found++;
            end
        end
        if (found == 0) begin
            res = '{event_time: '0, incidence: '0, empty_result: 1'b1,
                    overflowed: run_overflow, last_result: 1'b1};
            pending_results.insert(pending_results.size(), res);
            n_empty_runs++;
        end else begin
            pending_results[pending_results.size()-1].last_result = 1'b1;
        end
        n_runs++;
        if (run_overflow) n_overflow_runs++;
        run_times.delete();
        run_events.delete();
        run_overflow = 1'b0;
    endtask

    // directed table; fixed rows end a run that has exactly one result
    typedef struct {
        t_in  item;
        logic has_fixed;
        t_out fixed;
    } t_row;
    t_row dir_table[$];

    function automatic void add_row(t_row rw);
        dir_table.insert(dir_table.size(), rw);
    endfunction

    function automatic t_in mk(logic [31:0] tm, logic ev, logic ms, logic ls);
        mk = '{obs_time: tm, is_event: ev, is_missing: ms, last_obs: ls};
    endfunction

    function automatic t_row row(t_in it);
        row = '{item: it, has_fixed: 1'b0, fixed: '0};
    endfunction

    function automatic t_row row_fixed(t_in it, t_out f);
        row_fixed = '{item: it, has_fixed: 1'b1, fixed: f};
    endfunction

    // output monitor: compare each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out ex;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: time=%0d inc=%0d", o_out.event_time,
                       o_out.incidence);
                errors++;
            end else begin
                ex = pending_results.pop_front();
                if (o_out.event_time !== ex.event_time) begin
                    $error("event_time: expected %0d actual %0d", ex.event_time,
                           o_out.event_time);
                    errors++;
                end
                if (o_out.incidence !== ex.incidence) begin
                    $error("incidence: expected %0d actual %0d", ex.incidence,
                           o_out.incidence);
                    errors++;
                end
                if (o_out.empty_result !== ex.empty_result) begin
                    $error("empty_result: expected %0b actual %0b", ex.empty_result,
                           o_out.empty_result);
                    errors++;
                end
                if (o_out.overflowed !== ex.overflowed) begin
                    $error("overflowed: expected %0b actual %0b", ex.overflowed,
                           o_out.overflowed);
                    errors++;
                end
                if (o_out.last_result !== ex.last_result) begin
                    $error("last_result: expected %0b actual %0b", ex.last_result,
                           o_out.last_result);
                    errors++;
                end
                n_results++;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stall, with one long hold-off while input keeps coming
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= 1'b1;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        int hold_cycles;
        wait (n_runs >= 3);
        hold_off = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 3000) begin
            @(posedge i_clk);
            hold_cycles++;
        end
        hold_off = 1'b0;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // send one transfer, honoring stall; predict on acceptance
    task automatic send(input t_in it);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_survival(it);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_time(int mode);
        case (mode)
            0: rand_time = $urandom_range(0, 15);
            1: rand_time = $urandom();
            default: rand_time = $urandom_range(0, 200);
        endcase
    endfunction

    initial begin
        int items, len, mode;
        t_out f;
        // empty run, extremes, ties, missing end
        f = '{event_time: '0, incidence: '0, empty_result: 1'b1, overflowed: 1'b0,
              last_result: 1'b1};
        add_row(row_fixed(mk(32'd0, 1'b0, 1'b1, 1'b1), f));
        f = '{event_time: 32'hFFFF_FFFF, incidence: OneQ16, empty_result: 1'b0,
              overflowed: 1'b0, last_result: 1'b1};
        add_row(row_fixed(mk(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1), f));
        add_row(row(mk(32'd5, 1'b1, 1'b0, 1'b0)));
        add_row(row(mk(32'd5, 1'b0, 1'b0, 1'b0)));
        add_row(row(mk(32'd5, 1'b1, 1'b0, 1'b0)));
        add_row(row(mk(32'd0, 1'b1, 1'b0, 1'b0)));
        add_row(row(mk(32'hAAAA_5555, 1'b1, 1'b1, 1'b0)));
        add_row(row(mk(32'h8000_0000, 1'b0, 1'b0, 1'b0)));
        add_row(row(mk(32'd3, 1'b1, 1'b0, 1'b0)));
        add_row(row(mk(32'd0, 1'b0, 1'b1, 1'b1)));
        f = '{event_time: '0, incidence: '0, empty_result: 1'b1, overflowed: 1'b0,
              last_result: 1'b1};
        add_row(row_fixed(mk(32'd7, 1'b0, 1'b0, 1'b1), f));
        add_row(row(mk(32'h5555_AAAA, 1'b0, 1'b0, 1'b0)));
        add_row(row(mk(32'h5555_AAAA, 1'b1, 1'b0, 1'b1)));

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[k]) begin
            send(dir_table[k].item);
            if (dir_table[k].has_fixed &&
                pending_results[pending_results.size()-1] !== dir_table[k].fixed) begin
                $error("fixed row %0d: predictor disagrees with table", k);
                errors++;
            end
        end

        // overflow run: 64 stored plus dropped ones
        for (int k = 0; k < 70; k++)
            send(mk($urandom_range(0, 30), 1'($urandom()), 1'b0, k == 69));
        items = 13 + 70;

        // random runs with mostly small sizes and small time ranges for ties
        while (items < 410) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < len; k++) begin
                send(mk(rand_time(mode), 1'($urandom()), $urandom_range(0, 9) == 0,
                        k == len - 1));
                items++;
            end
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Ran %0d runs (%0d empty, %0d with dropped observations), %0d results.",
                 n_runs, n_empty_runs, n_overflow_runs, n_results);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
